// ===== rtl/sorted_reminder_table_top_macros.svh =====
// Assertion macros for the sorted reminder table.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef SORTED_REMINDER_TABLE_TOP_MACROS_SVH
`define SORTED_REMINDER_TABLE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SRT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/srt_pkg.sv =====
// Shared types and constants for the sorted reminder table.
// Used by srt_ram, sorted_reminder_table_top and the testbench; no dependencies.
`default_nettype none

package srt_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int SLOT_W        = 6;
  localparam int DAY_W         = 5;
  localparam int HOUR_W        = 5;
  localparam int MIN_W         = 6;
  localparam int TAG_W         = 32;

  localparam logic [HOUR_W-1:0] HOUR_MAX = HOUR_W'(23);
  localparam logic [MIN_W-1:0]  MIN_MAX  = MIN_W'(59);

  localparam logic ACT_INSERT   = 1'b0;
  localparam logic ACT_READ_OUT = 1'b1;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_BAD_TIME = 3'd2,
    ST_READ     = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [HOUR_W-1:0] hours;
    logic [MIN_W-1:0]  minutes;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  function automatic logic [DAY_W+HOUR_W+MIN_W-1:0] time_key(input entry_t e);
    time_key = {e.day, e.hours, e.minutes};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sorted_reminder_table_top.sv =====
// Sorted reminder table: insertion-sorted entry store with ordered read-out.
// Depends on srt_pkg, srt_ram and sorted_reminder_table_top_macros.svh.
//
//   channel | direction | handshake          | payload
//   in      | receive   | in_valid/in_stall  | action day hours minutes message_tag
//   out     | send      | out_valid/out_stall| status slot out_day out_hours
//           |           |                    | out_minutes out_tag last
//
// Insert: each entry moved down is read, then written back one slot later; the single
//   store port pair sets the pace, and the walk ends in the response step.
// Read-out: each entry takes a store read, then an output load; 1 result per entry.
// Rejected inserts and empty read-out go straight to the response. Reset empties the table at once.
// An output stall holds the engine at its next output load; the next transaction is taken as soon
// as the last result sits in the output register.
`default_nettype none

module sorted_reminder_table_top #(
  parameter int TABLE_DEPTH = srt_pkg::DEPTH_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        action,
  input  wire logic [srt_pkg::DAY_W-1:0]   day,
  input  wire logic [srt_pkg::HOUR_W-1:0]  hours,
  input  wire logic [srt_pkg::MIN_W-1:0]   minutes,
  input  wire logic [srt_pkg::TAG_W-1:0]   message_tag,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [2:0]                       status,
  output logic [srt_pkg::SLOT_W-1:0]       slot,
  output logic [srt_pkg::DAY_W-1:0]        out_day,
  output logic [srt_pkg::HOUR_W-1:0]       out_hours,
  output logic [srt_pkg::MIN_W-1:0]        out_minutes,
  output logic [srt_pkg::TAG_W-1:0]        out_tag,
  output logic                             last
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_RESP,
    S_OUT_RD,
    S_OUT_LD
  } state_t;

  state_t                       state;
  logic [CNT_W-1:0]             count;
  logic [IDX_W-1:0]             pos;
  logic [IDX_W-1:0]             idx;
  srt_pkg::entry_t              ins;
  srt_pkg::status_t             resp_status;
  logic [srt_pkg::SLOT_W-1:0]   resp_slot;

  logic                         mem_we;
  logic [IDX_W-1:0]             mem_waddr;
  srt_pkg::entry_t              mem_wdata;
  logic                         mem_re;
  logic [IDX_W-1:0]             mem_raddr;
  srt_pkg::entry_t              mem_rdata;

  logic                         out_free;
  logic                         out_load;
  logic                         key_gt;
  logic                         last_entry;
  logic                         table_full;
  logic                         bad_time;

  srt_ram #(
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_stall   = (state != S_IDLE);
  assign out_free   = !out_valid || !out_stall;
  assign out_load   = ((state == S_RESP) || (state == S_OUT_LD)) && out_free;
  assign key_gt     = srt_pkg::time_key(mem_rdata) > srt_pkg::time_key(ins);
  assign last_entry = (CNT_W'(idx) + CNT_W'(1)) == count;
  assign table_full = (count == CNT_W'(TABLE_DEPTH));
  assign bad_time   = (day == '0) || (hours > srt_pkg::HOUR_MAX) ||
                      (minutes > srt_pkg::MIN_MAX);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos;
    mem_wdata = ins;
    mem_re    = 1'b0;
    mem_raddr = pos - IDX_W'(1);
    case (state)
      S_INS_RD: begin
        if (pos == '0) begin
          mem_we = 1'b1;
        end else begin
          mem_re = 1'b1;
        end
      end
      S_INS_CMP: begin
        mem_we = 1'b1;
        if (key_gt) begin
          mem_wdata = mem_rdata;
        end
      end
      S_OUT_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            ins <= '{day: day, hours: hours, minutes: minutes, tag: message_tag};
            resp_slot <= '0;
            if (action == srt_pkg::ACT_READ_OUT) begin
              if (count == '0) begin
                resp_status <= srt_pkg::ST_EMPTY;
                state       <= S_RESP;
              end else begin
                idx   <= '0;
                state <= S_OUT_RD;
              end
            end else if (table_full) begin
              resp_status <= srt_pkg::ST_FULL;
              state       <= S_RESP;
            end else if (bad_time) begin
              resp_status <= srt_pkg::ST_BAD_TIME;
              state       <= S_RESP;
            end else begin
              pos   <= IDX_W'(count);
              state <= S_INS_RD;
            end
          end
        end
        S_INS_RD: begin
          if (pos == '0) begin
            count       <= count + CNT_W'(1);
            resp_status <= srt_pkg::ST_INSERTED;
            resp_slot   <= '0;
            state       <= S_RESP;
          end else begin
            state <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (key_gt) begin
            pos   <= pos - IDX_W'(1);
            state <= S_INS_RD;
          end else begin
            count       <= count + CNT_W'(1);
            resp_status <= srt_pkg::ST_INSERTED;
            resp_slot   <= srt_pkg::SLOT_W'(pos);
            state       <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_free) begin
            status      <= resp_status;
            slot        <= resp_slot;
            out_day     <= '0;
            out_hours   <= '0;
            out_minutes <= '0;
            out_tag     <= '0;
            last        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_OUT_RD: begin
          state <= S_OUT_LD;
        end
        S_OUT_LD: begin
          if (out_free) begin
            status      <= srt_pkg::ST_READ;
            slot        <= srt_pkg::SLOT_W'(idx);
            out_day     <= mem_rdata.day;
            out_hours   <= mem_rdata.hours;
            out_minutes <= mem_rdata.minutes;
            out_tag     <= mem_rdata.tag;
            last        <= last_entry;
            if (last_entry) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= S_OUT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "sorted_reminder_table_top_macros.svh"

  `SRT_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(TABLE_DEPTH),
                   "entry count above depth")
  `SRT_ASSERT_IMPL(a_write_in_table, clk, rst, mem_we, CNT_W'(mem_waddr) <= count,
                   "store write beyond fill")
  `SRT_ASSERT_NEXT(a_count_step, clk, rst, 1'b1,
                   (count == $past(count)) || (count == $past(count) + CNT_W'(1)),
                   "entry count jumped")
  `SRT_ASSERT_NEXT(a_readout_end, clk, rst, (state == S_OUT_LD) && out_free && last_entry,
                   (state == S_IDLE) && out_valid && last, "read-out did not close")

endmodule

`default_nettype wire

// ===== rtl/srt_ram.sv =====
// Entry store: one write port, one read port, registered read data.
// Depends on srt_pkg for the entry layout.
`default_nettype none

module srt_ram #(
  parameter int DEPTH = srt_pkg::DEPTH_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire srt_pkg::entry_t            wdata,
  input  wire logic                       re,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output srt_pkg::entry_t                 rdata
);

  srt_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for sorted_reminder_table_top: random and directed inserts and read-outs,
// checked result by result against a scoreboard that keeps its own sorted table.
// Depends on srt_pkg and the RTL of sorted_reminder_table_top.
`timescale 1ns / 100ps

module tb;
  import srt_pkg::*;

  localparam int DEPTH       = DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN       = 2 * DEPTH + 8;

  typedef struct {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [DAY_W-1:0]  day;
    logic [HOUR_W-1:0] hours;
    logic [MIN_W-1:0]  minutes;
    logic [TAG_W-1:0]  tag;
    logic              last;
  } reminder_result_t;

  class reminder_scoreboard;
    entry_t           entries[$];
    reminder_result_t pending[$];
    int               depth;
    int               mismatches;

    function new(int table_depth);
      depth = table_depth;
      mismatches = 0;
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
    endtask

    function reminder_result_t make_result(status_t st, int pos, entry_t e, logic fin);
      reminder_result_t r;
      r.status  = st;
      r.slot    = SLOT_W'(pos);
      r.day     = e.day;
      r.hours   = e.hours;
      r.minutes = e.minutes;
      r.tag     = e.tag;
      r.last    = fin;
      return r;
    endfunction

    function void note_request(logic act, logic [DAY_W-1:0] d, logic [HOUR_W-1:0] h,
                               logic [MIN_W-1:0] m, logic [TAG_W-1:0] tag);
      entry_t e;
      int     pos;
      e = '0;
      if (act == ACT_READ_OUT) begin
        if (entries.size() == 0) begin
          pending.push_back(make_result(ST_EMPTY, 0, e, 1'b1));
        end else begin
          foreach (entries[i])
            pending.push_back(make_result(ST_READ, i, entries[i], i == entries.size() - 1));
        end
      end else if (entries.size() >= depth) begin
        pending.push_back(make_result(ST_FULL, 0, e, 1'b1));
      end else if (d == '0 || h > HOUR_MAX || m > MIN_MAX) begin
        pending.push_back(make_result(ST_BAD_TIME, 0, e, 1'b1));
      end else begin
        e.day = d;
        e.hours = h;
        e.minutes = m;
        e.tag = tag;
        pos = 0;
        while (pos < entries.size() &&
               {entries[pos].day, entries[pos].hours, entries[pos].minutes} <= {d, h, m})
          pos++;
        entries.insert(pos, e);
        pending.push_back(make_result(ST_INSERTED, pos, '0, 1'b1));
      end
    endfunction

    task check_result(logic [2:0] st, logic [SLOT_W-1:0] sl, logic [DAY_W-1:0] d,
                      logic [HOUR_W-1:0] h, logic [MIN_W-1:0] m, logic [TAG_W-1:0] tag,
                      logic fin);
      reminder_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result, status %0d slot %0d", st, sl));
        return;
      end
      want = pending.pop_front();
      if (st !== want.status)
        report($sformatf("status %0d, want %s", st, want.status.name()));
      if (sl !== want.slot) report($sformatf("slot %0d, want %0d", sl, want.slot));
      if (d !== want.day) report($sformatf("out_day %0d, want %0d", d, want.day));
      if (h !== want.hours) report($sformatf("out_hours %0d, want %0d", h, want.hours));
      if (m !== want.minutes)
        report($sformatf("out_minutes %0d, want %0d", m, want.minutes));
      if (tag !== want.tag) report($sformatf("out_tag %h, want %h", tag, want.tag));
      if (fin !== want.last) report($sformatf("last %b, want %b", fin, want.last));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              action = ACT_INSERT;
  logic [DAY_W-1:0]  day = '0;
  logic [HOUR_W-1:0] hours = '0;
  logic [MIN_W-1:0]  minutes = '0;
  logic [TAG_W-1:0]  message_tag = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        status;
  logic [SLOT_W-1:0] slot;
  logic [DAY_W-1:0]  out_day;
  logic [HOUR_W-1:0] out_hours;
  logic [MIN_W-1:0]  out_minutes;
  logic [TAG_W-1:0]  out_tag;
  logic              last;

  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  int                 cycles = 0;
  reminder_scoreboard sb = new(DEPTH);

  sorted_reminder_table_top #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .day(day), .hours(hours), .minutes(minutes),
    .message_tag(message_tag),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .slot(slot), .out_day(out_day), .out_hours(out_hours),
    .out_minutes(out_minutes), .out_tag(out_tag), .last(last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // check each transaction leaving the block, then pick the next stall
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        sb.check_result(status, slot, out_day, out_hours, out_minutes, out_tag, last);
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_request(logic act, logic [DAY_W-1:0] d, logic [HOUR_W-1:0] h,
                              logic [MIN_W-1:0] m, logic [TAG_W-1:0] tag);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    day         <= d;
    hours       <= h;
    minutes     <= m;
    message_tag <= tag;
    do @(posedge clk); while (in_stall);
    sb.note_request(act, d, h, m, tag);
  endtask

  task automatic send_random_request();
    int                pick;
    logic              act;
    logic [DAY_W-1:0]  d;
    logic [HOUR_W-1:0] h;
    logic [MIN_W-1:0]  m;
    pick = $urandom_range(99);
    d = DAY_W'($urandom);
    h = HOUR_W'($urandom);
    m = MIN_W'($urandom);
    act = ACT_INSERT;
    if (pick < 12) begin
      act = ACT_READ_OUT;
    end else if (pick < 25) begin
      case ($urandom_range(2))
        0: d = '0;
        1: h = HOUR_W'($urandom_range(31, 24));
        default: m = MIN_W'($urandom_range(63, 60));
      endcase
    end else if ($urandom_range(2) == 0) begin
      // crowd a few keys so that equal times meet often
      d = DAY_W'($urandom_range(3, 1));
      h = HOUR_W'($urandom_range(1, 0));
      m = MIN_W'($urandom_range(2, 0));
    end else begin
      d = DAY_W'($urandom_range(31, 1));
      h = HOUR_W'($urandom_range(23, 0));
      m = MIN_W'($urandom_range(59, 0));
    end
    send_request(act, d, h, m, $urandom);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 36;
    recv_idle_pct = 52;
    send_request(ACT_READ_OUT, '0, '0, '0, '0);
    send_request(ACT_INSERT, 5'd0, 5'd0, 6'd0, 32'h1111_1111);
    send_request(ACT_INSERT, 5'd5, 5'd24, 6'd0, 32'h2222_2222);
    send_request(ACT_INSERT, 5'd5, 5'd31, 6'd63, 32'hffff_ffff);
    send_request(ACT_INSERT, 5'd5, 5'd10, 6'd60, 32'h3333_3333);
    send_request(ACT_INSERT, 5'd31, 5'd23, 6'd59, 32'hffff_ffff);
    send_request(ACT_INSERT, 5'd1, 5'd0, 6'd0, 32'h0000_0000);
    send_request(ACT_INSERT, 5'd16, 5'd16, 6'd32, 32'ha5a5_a5a5);
    send_request(ACT_INSERT, 5'd16, 5'd16, 6'd32, 32'h5a5a_5a5a);
    send_request(ACT_INSERT, 5'd16, 5'd15, 6'd59, 32'h0f0f_0f0f);
    send_request(ACT_INSERT, 5'd16, 5'd16, 6'd31, 32'hf0f0_f0f0);
    send_request(ACT_INSERT, 5'd31, 5'd23, 6'd59, 32'h0000_0001);
    send_request(ACT_INSERT, 5'd1, 5'd0, 6'd0, 32'h8000_0000);
    send_request(ACT_INSERT, 5'd15, 5'd7, 6'd15, 32'h7fff_ffff);
    send_request(ACT_READ_OUT, 5'd31, 5'd31, 6'd63, 32'hffff_ffff);
    send_request(ACT_INSERT, 5'd0, 5'd31, 6'd63, 32'hffff_ffff);
    send_request(ACT_INSERT, 5'd31, 5'd23, 6'd60, 32'h1234_5678);

    repeat (38) send_random_request();
    send_idle_pct = 52;
    recv_idle_pct = 36;
    repeat (38) send_random_request();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (38) send_random_request();
    send_request(ACT_READ_OUT, '0, '0, '0, '0);
    in_valid <= 1'b0;

    // drain the outstanding results, then hold for stragglers
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
